// ----- rtl/spc_pkg.sv -----
// Shared constants and types for the shape pair collision test.
`timescale 1ns / 1ps
package spc_pkg;

  localparam int COORD_WIDTH_DEF = 16;
  localparam int QUEUE_AW        = 2;   // 4-entry queues

  localparam logic [2:0] KIND_PT_BOX   = 3'd0;
  localparam logic [2:0] KIND_PT_CIRC  = 3'd1;
  localparam logic [2:0] KIND_BOX_BOX  = 3'd2;
  localparam logic [2:0] KIND_CIRC_CIRC = 3'd3;
  localparam logic [2:0] KIND_BOX_CIRC = 3'd4;

  // Geometric flags for the box-circle test, taken before the squares.
  typedef struct packed {
    logic in_h;       // center projects strictly inside the horizontal edges
    logic in_v;       // center projects strictly inside the vertical edges
    logic ctr_in;     // center inside the box, edges included
    logic near_bot;
    logic near_left;
    logic near_top;
    logic near_right;
  } spc_flags_t;

endpackage

// ----- rtl/spc_queue.sv -----
// Small register queue with push/full and pop/empty sides.
`timescale 1ns / 1ps
module spc_queue #(
  parameter int W  = 8,
  parameter int AW = 2
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] din,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] dout,
  output logic         empty
);

  localparam int DEPTH = 1 << AW;

  logic [W-1:0] mem [DEPTH];
  logic [AW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [AW:0]   cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign full    = (cnt_r == (AW+1)'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rp_r];

  always_comb begin
    wp_nxt  = do_push ? wp_r + 1'b1 : wp_r;
    rp_nxt  = do_pop ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r + (AW+1)'(do_push) - (AW+1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wp_r] <= din;
    end
  end

endmodule

// ----- rtl/spc_front.sv -----
// Front end: takes a request apart into offsets, radius and the box-only answers.
`timescale 1ns / 1ps
module spc_front import spc_pkg::*; #(
  parameter int CW = COORD_WIDTH_DEF
) (
  input  logic                 [2:0]    req_type,
  input  logic signed          [CW-1:0] a_x,
  input  logic signed          [CW-1:0] a_y,
  input  logic                 [CW-2:0] a_w,
  input  logic                 [CW-2:0] a_h,
  input  logic                 [CW-2:0] a_r,
  input  logic signed          [CW-1:0] b_x,
  input  logic signed          [CW-1:0] b_y,
  input  logic                 [CW-2:0] b_w,
  input  logic                 [CW-2:0] b_h,
  input  logic                 [CW-2:0] b_r,
  output logic signed          [CW+1:0] dx0,
  output logic signed          [CW+1:0] dx1,
  output logic signed          [CW+1:0] dy0,
  output logic signed          [CW+1:0] dy1,
  output logic                 [CW-1:0] rad,
  output logic                          pre_hit
);

  localparam int DW = CW + 2;

  logic signed [DW-1:0] ax_e, ay_e, bx_e, by_e, aw_e, ah_e, bw_e, bh_e;
  logic signed [DW-1:0] ax1, ay1, bx1, by1;
  logic                 pt_in, box_ov;

  always_comb begin
    ax_e = DW'(a_x);
    ay_e = DW'(a_y);
    bx_e = DW'(b_x);
    by_e = DW'(b_y);
    aw_e = $signed(DW'(a_w));
    ah_e = $signed(DW'(a_h));
    bw_e = $signed(DW'(b_w));
    bh_e = $signed(DW'(b_h));
    ax1  = ax_e + aw_e;
    ay1  = ay_e + ah_e;
    bx1  = bx_e + bw_e;
    by1  = by_e + bh_e;

    // center of circle b relative to the corners of box a
    dx0 = bx_e - ax_e;
    dx1 = bx_e - ax1;
    dy0 = by_e - ay_e;
    dy1 = by_e - ay1;

    rad = (req_type == KIND_CIRC_CIRC) ? CW'(a_r) + CW'(b_r) : CW'(b_r);

    pt_in  = (ax_e >= bx_e) && (ax_e <= bx1) && (ay_e >= by_e) && (ay_e <= by1);
    box_ov = (ax1 >= bx_e) && (ax_e <= bx1) && (ay1 >= by_e) && (ay_e <= by1);

    unique case (req_type)
      KIND_PT_BOX:  pre_hit = pt_in;
      KIND_BOX_BOX: pre_hit = box_ov;
      default:      pre_hit = 1'b0;
    endcase
  end

endmodule

// ----- rtl/spc_back.sv -----
// Back end: squares, corner distances and the final compare, into the result queue.
`timescale 1ns / 1ps
module spc_back import spc_pkg::*; #(
  parameter int CW = COORD_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 mid_empty,
  output logic                 mid_pop,
  input  logic [2:0]           kind,
  input  logic signed [CW+1:0] dx0,
  input  logic signed [CW+1:0] dx1,
  input  logic signed [CW+1:0] dy0,
  input  logic signed [CW+1:0] dy1,
  input  logic [CW-1:0]        rad,
  input  logic                 pre_hit,
  output logic                 out_empty,
  input  logic                 out_pop,
  output logic                 out_hit
);

  localparam int DW   = CW + 2;
  localparam int SQW  = 2 * DW;
  localparam int SUMW = SQW + 1;

  logic                  s1_v_r, s1_v_nxt;
  logic [2:0]            s1_kind_r;
  logic                  s1_pre_r;
  spc_flags_t            s1_fl_r, fl;
  logic [SQW-1:0]        sx0_r, sx1_r, sy0_r, sy1_r, rr_r;
  logic signed [2*DW-1:0] px0, px1, py0, py1;
  logic signed [DW-1:0]  rs;
  logic [2*CW-1:0]       rsq;
  logic                  adv, q_full, q_push, hit;
  logic [SUMW-1:0]       c00, c10, c01, c11, rrw;
  logic                  e_bot, e_left, e_top, e_right;

  function automatic logic edge_ok(input logic [SUMW-1:0] p, input logic [SUMW-1:0] q,
                                   input logic [SUMW-1:0] rr, input logic proj_in,
                                   input logic perp_ok);
    logic [SUMW-1:0] nr, fr;
    nr = (p <= q) ? p : q;
    fr = (p <= q) ? q : p;
    return (proj_in ? perp_ok : (nr <= rr)) && (rr <= fr);
  endfunction

  // stage 1: multipliers and flags
  assign adv     = !(s1_v_r && q_full);
  assign mid_pop = adv && !mid_empty;
  assign s1_v_nxt = adv ? !mid_empty : s1_v_r;

  always_comb begin
    px0 = dx0 * dx0;
    px1 = dx1 * dx1;
    py0 = dy0 * dy0;
    py1 = dy1 * dy1;
    rsq = CW'(rad) * CW'(rad);
    rs  = $signed(DW'(rad));
    fl.in_h       = (dx0 > 0) && (dx1 < 0);
    fl.in_v       = (dy0 > 0) && (dy1 < 0);
    fl.ctr_in     = (dx0 >= 0) && (dx1 <= 0) && (dy0 >= 0) && (dy1 <= 0);
    fl.near_bot   = (dy0 <= rs) && (dy0 >= -rs);
    fl.near_left  = (dx0 <= rs) && (dx0 >= -rs);
    fl.near_top   = (dy1 <= rs) && (dy1 >= -rs);
    fl.near_right = (dx1 <= rs) && (dx1 >= -rs);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_kind_r <= kind;
      s1_pre_r  <= pre_hit;
      s1_fl_r   <= fl;
      sx0_r     <= $unsigned(px0);
      sx1_r     <= $unsigned(px1);
      sy0_r     <= $unsigned(py0);
      sy1_r     <= $unsigned(py1);
      rr_r      <= SQW'(rsq);
    end
  end

  // stage 2: corner distances and compares
  always_comb begin
    c00 = SUMW'(sx0_r) + SUMW'(sy0_r);
    c10 = SUMW'(sx1_r) + SUMW'(sy0_r);
    c01 = SUMW'(sx0_r) + SUMW'(sy1_r);
    c11 = SUMW'(sx1_r) + SUMW'(sy1_r);
    rrw = SUMW'(rr_r);
    e_bot   = edge_ok(c00, c10, rrw, s1_fl_r.in_h, s1_fl_r.near_bot);
    e_left  = edge_ok(c00, c01, rrw, s1_fl_r.in_v, s1_fl_r.near_left);
    e_top   = edge_ok(c11, c01, rrw, s1_fl_r.in_h, s1_fl_r.near_top);
    e_right = edge_ok(c11, c10, rrw, s1_fl_r.in_v, s1_fl_r.near_right);
    unique case (s1_kind_r)
      KIND_PT_BOX, KIND_BOX_BOX:    hit = s1_pre_r;
      KIND_PT_CIRC, KIND_CIRC_CIRC: hit = (c00 <= rrw);
      KIND_BOX_CIRC: hit = s1_fl_r.ctr_in || e_bot || e_left || e_top || e_right;
      default:       hit = 1'b0;
    endcase
  end

  assign q_push = s1_v_r && !q_full;

  spc_queue #(.W(1), .AW(QUEUE_AW)) u_outq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (hit),
    .full  (q_full),
    .pop   (out_pop),
    .dout  (out_hit),
    .empty (out_empty)
  );

endmodule

// ----- rtl/shape_pair_collision_test.sv -----
// Top level of the shape pair collision test.
`timescale 1ns / 1ps
// Exact 2D overlap tests between shape pairs (point/box/circle, five kinds), one
// result beat per request beat, in order. A new request is taken every cycle
// while in_full is low; from accept to result visible a request passes the
// request queue, one multiplier stage and the compare into the result queue. The
// request and result sides each have a 4-entry queue, so a stalled reader
// backs up into in_full only after both queues and the multiplier stage fill.
module shape_pair_collision_test import spc_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_push,
  output logic                          in_full,
  input  logic        [2:0]             in_req_type,
  input  logic signed [COORD_WIDTH-1:0] in_a_x,
  input  logic signed [COORD_WIDTH-1:0] in_a_y,
  input  logic        [COORD_WIDTH-2:0] in_a_w,
  input  logic        [COORD_WIDTH-2:0] in_a_h,
  input  logic        [COORD_WIDTH-2:0] in_a_r,
  input  logic signed [COORD_WIDTH-1:0] in_b_x,
  input  logic signed [COORD_WIDTH-1:0] in_b_y,
  input  logic        [COORD_WIDTH-2:0] in_b_w,
  input  logic        [COORD_WIDTH-2:0] in_b_h,
  input  logic        [COORD_WIDTH-2:0] in_b_r,
  output logic                          out_empty,
  input  logic                          out_pop,
  output logic                          out_hit
);

  localparam int CW = COORD_WIDTH;
  localparam int DW = CW + 2;
  localparam int EW = 3 + 4 * DW + CW + 1;

  logic signed [DW-1:0] f_dx0, f_dx1, f_dy0, f_dy1;
  logic [CW-1:0]        f_rad;
  logic                 f_pre;
  logic [EW-1:0]        mid_din, mid_dout;
  logic                 mid_full, mid_empty, mid_pop;

  spc_front #(.CW(CW)) u_front (
    .req_type (in_req_type),
    .a_x      (in_a_x),
    .a_y      (in_a_y),
    .a_w      (in_a_w),
    .a_h      (in_a_h),
    .a_r      (in_a_r),
    .b_x      (in_b_x),
    .b_y      (in_b_y),
    .b_w      (in_b_w),
    .b_h      (in_b_h),
    .b_r      (in_b_r),
    .dx0      (f_dx0),
    .dx1      (f_dx1),
    .dy0      (f_dy0),
    .dy1      (f_dy1),
    .rad      (f_rad),
    .pre_hit  (f_pre)
  );

  assign mid_din = {in_req_type, f_dx0, f_dx1, f_dy0, f_dy1, f_rad, f_pre};
  assign in_full = mid_full;

  spc_queue #(.W(EW), .AW(QUEUE_AW)) u_midq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_push),
    .din   (mid_din),
    .full  (mid_full),
    .pop   (mid_pop),
    .dout  (mid_dout),
    .empty (mid_empty)
  );

  spc_back #(.CW(CW)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .mid_empty (mid_empty),
    .mid_pop   (mid_pop),
    .kind      (mid_dout[EW-1 -: 3]),
    .dx0       ($signed(mid_dout[EW-4 -: DW])),
    .dx1       ($signed(mid_dout[EW-4-DW -: DW])),
    .dy0       ($signed(mid_dout[EW-4-2*DW -: DW])),
    .dy1       ($signed(mid_dout[EW-4-3*DW -: DW])),
    .rad       (mid_dout[CW:1]),
    .pre_hit   (mid_dout[0]),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_hit   (out_hit)
  );

`ifndef SYNTH
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty && !in_full)
    else $error("queues not empty after reset");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    mid_pop |-> !mid_empty)
    else $error("back end popped an empty request queue");
  a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
    in_push && !in_full |=> !mid_empty)
    else $error("accepted request beat lost");
`endif

endmodule

// ----- dv/shape_pair_collision_checker.sv -----
// Checker for the shape pair collision test: predicts hit per request beat and compares.
`timescale 1ns / 1ps
module shape_pair_collision_checker import spc_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  input  logic               in_full,
  input  logic        [2:0]  in_req_type,
  input  logic signed [15:0] in_a_x,
  input  logic signed [15:0] in_a_y,
  input  logic        [14:0] in_a_w,
  input  logic        [14:0] in_a_h,
  input  logic        [14:0] in_a_r,
  input  logic signed [15:0] in_b_x,
  input  logic signed [15:0] in_b_y,
  input  logic        [14:0] in_b_w,
  input  logic        [14:0] in_b_h,
  input  logic        [14:0] in_b_r,
  input  logic               out_empty,
  input  logic               out_pop,
  input  logic               out_hit,
  output int                 fail_count,
  output int                 pending_hits
);

  bit hit_queue[$];

  assign pending_hits = hit_queue.size();

  function automatic longint sq(longint v);
    return v * v;
  endfunction

  function automatic bit pt_in_box(longint px, longint py, longint bx, longint by,
                                   longint bw, longint bh);
    return px >= bx && px <= bx + bw && py >= by && py <= by + bh;
  endfunction

  function automatic bit same_sign(longint a, longint b);
    return (a > 0 && b > 0) || (a < 0 && b < 0);
  endfunction

  // Axis-aligned edge p..q against circle (cx, cy, r).
  function automatic bit edge_touch(longint cx, longint cy, longint r, bit horiz,
                                    longint px, longint py, longint qx, longint qy);
    longint d1, d2, rr, dnear, dfar, perp;
    bit strict_in, near_ok;
    d1 = sq(cx - px) + sq(cy - py);
    d2 = sq(cx - qx) + sq(cy - qy);
    rr = sq(r);
    dnear = (d1 <= d2) ? d1 : d2;
    dfar  = (d1 <= d2) ? d2 : d1;
    if (horiz) begin
      strict_in = same_sign(cx - px, qx - px) && same_sign(cx - qx, px - qx);
      perp = cy - py;
    end else begin
      strict_in = same_sign(cy - py, qy - py) && same_sign(cy - qy, py - qy);
      perp = cx - px;
    end
    if (perp < 0) perp = -perp;
    near_ok = strict_in ? (perp <= r) : (dnear <= rr);
    return near_ok && rr <= dfar;
  endfunction

  function automatic bit predict_hit(logic [2:0] kind, longint ax, longint ay, longint aw,
                                     longint ah, longint ar, longint bx, longint by,
                                     longint bw, longint bh, longint br);
    case (kind)
      KIND_PT_BOX:    return pt_in_box(ax, ay, bx, by, bw, bh);
      KIND_PT_CIRC:   return sq(ax - bx) + sq(ay - by) <= sq(br);
      KIND_BOX_BOX:   return !(ax + aw < bx || ax > bx + bw) && !(ay + ah < by || ay > by + bh);
      KIND_CIRC_CIRC: return sq(ax - bx) + sq(ay - by) <= sq(ar + br);
      KIND_BOX_CIRC:
        return pt_in_box(bx, by, ax, ay, aw, ah)
          || edge_touch(bx, by, br, 1'b1, ax, ay, ax + aw, ay)
          || edge_touch(bx, by, br, 1'b0, ax, ay, ax, ay + ah)
          || edge_touch(bx, by, br, 1'b1, ax + aw, ay + ah, ax, ay + ah)
          || edge_touch(bx, by, br, 1'b0, ax + aw, ay + ah, ax + aw, ay);
      default:        return 1'b0;
    endcase
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      hit_queue.delete();
      fail_count <= 0;
    end else begin
      if (in_push && !in_full)
        hit_queue.push_back(predict_hit(in_req_type, in_a_x, in_a_y, in_a_w, in_a_h, in_a_r,
                                        in_b_x, in_b_y, in_b_w, in_b_h, in_b_r));
      if (out_pop && !out_empty) begin
        if (hit_queue.size() == 0) begin
          $error("hit beat with nothing expected: actual %0b", out_hit);
          fail_count <= fail_count + 1;
        end else if (hit_queue[0] !== out_hit) begin
          $error("field hit: expected %0b actual %0b", hit_queue[0], out_hit);
          fail_count <= fail_count + 1;
          void'(hit_queue.pop_front());
        end else begin
          void'(hit_queue.pop_front());
        end
      end
    end
  end

endmodule

// ----- dv/tb_shape_pair_collision_test.sv -----
// Testbench top for the shape pair collision test: stimulus, idling phases and verdict.
`timescale 1ns / 1ps
module tb_shape_pair_collision_test;
  import spc_pkg::*;

  localparam int N_RANDOM = 1300;
  localparam int CYCLE_LIMIT = 200000;

  logic clk, rst_n;
  logic in_push, in_full;
  logic [2:0] in_req_type;
  logic signed [15:0] in_a_x, in_a_y, in_b_x, in_b_y;
  logic [14:0] in_a_w, in_a_h, in_a_r, in_b_w, in_b_h, in_b_r;
  logic out_empty, out_pop, out_hit;
  int fail_count, pending_hits;
  int send_idle_pct, recv_stall_pct;
  bit hold_off;
  int cycle_count;

  shape_pair_collision_test u_dut (.*);

  shape_pair_collision_checker u_chk (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Timeout guard.
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off when asked.
  initial begin
    out_pop = 1'b0;
    forever begin
      @(posedge clk);
      out_pop <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic send_req(logic [2:0] kind, logic signed [15:0] ax, logic signed [15:0] ay,
                          logic [14:0] aw, logic [14:0] ah, logic [14:0] ar,
                          logic signed [15:0] bx, logic signed [15:0] by,
                          logic [14:0] bw, logic [14:0] bh, logic [14:0] br);
    while ($urandom_range(99) < send_idle_pct) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push <= 1'b1;
    in_req_type <= kind;
    in_a_x <= ax; in_a_y <= ay; in_a_w <= aw; in_a_h <= ah; in_a_r <= ar;
    in_b_x <= bx; in_b_y <= by; in_b_w <= bw; in_b_h <= bh; in_b_r <= br;
    @(posedge clk);
    while (in_full) @(posedge clk);
  endtask

  // Mostly nearby shapes so hits and misses both occur; some full-range noise.
  task automatic send_random();
    logic [2:0] kind;
    logic signed [15:0] ax, ay, bx, by;
    logic [14:0] aw, ah, ar, bw, bh, br;
    int span;
    kind = ($urandom_range(19) == 0) ? 3'($urandom_range(7, 5)) : 3'($urandom_range(4));
    if ($urandom_range(9) < 2) begin
      ax = 16'($urandom); ay = 16'($urandom); bx = 16'($urandom); by = 16'($urandom);
      aw = 15'($urandom); ah = 15'($urandom); ar = 15'($urandom);
      bw = 15'($urandom); bh = 15'($urandom); br = 15'($urandom);
    end else begin
      span = ($urandom_range(3) == 0) ? 8 : 200;
      ax = 16'($urandom); ay = 16'($urandom);
      bx = 16'(ax + $signed(16'($urandom_range(2 * span))) - span);
      by = 16'(ay + $signed(16'($urandom_range(2 * span))) - span);
      aw = 15'($urandom_range(span)); ah = 15'($urandom_range(span));
      ar = 15'($urandom_range(span));
      bw = 15'($urandom_range(span)); bh = 15'($urandom_range(span));
      br = 15'($urandom_range(span));
      if ($urandom_range(7) == 0) aw = '0;
      if ($urandom_range(7) == 0) ah = '0;
    end
    send_req(kind, ax, ay, aw, ah, ar, bx, by, bw, bh, br);
  endtask

  task automatic drain();
    in_push <= 1'b0;
    @(posedge clk);
    while (pending_hits != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  initial begin
    rst_n = 1'b0;
    in_push = 1'b0; in_req_type = '0;
    in_a_x = '0; in_a_y = '0; in_a_w = '0; in_a_h = '0; in_a_r = '0;
    in_b_x = '0; in_b_y = '0; in_b_w = '0; in_b_h = '0; in_b_r = '0;
    send_idle_pct = 0; recv_stall_pct = 0; hold_off = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: every kind, edges touching, zero-size boxes, field extremes.
    send_req(KIND_PT_BOX, 16'sd10, 16'sd20, 0, 0, 0, 16'sd10, 16'sd20, 0, 0, 0);
    send_req(KIND_PT_BOX, 16'sd31, 16'sd20, 0, 0, 0, 16'sd10, 16'sd20, 15'd20, 15'd5, 0);
    send_req(KIND_PT_BOX, 16'sd32767, 16'sd32767, 0, 0, 0, -16'sd32768, -16'sd32768,
             15'h7fff, 15'h7fff, 0);
    send_req(KIND_PT_CIRC, 16'sd3, 16'sd4, 0, 0, 0, 16'sd0, 16'sd0, 0, 0, 15'd5);
    send_req(KIND_PT_CIRC, 16'sd3, 16'sd5, 0, 0, 0, 16'sd0, 16'sd0, 0, 0, 15'd5);
    send_req(KIND_PT_CIRC, 16'sd32767, 16'sd32767, 0, 0, 0, -16'sd32768, -16'sd32768,
             0, 0, 15'h7fff);
    send_req(KIND_BOX_BOX, 16'sd0, 16'sd0, 15'd10, 15'd10, 0, 16'sd10, 16'sd10, 15'd5, 15'd5, 0);
    send_req(KIND_BOX_BOX, 16'sd0, 16'sd0, 15'd10, 15'd10, 0, 16'sd11, 16'sd0, 15'd5, 15'd5, 0);
    send_req(KIND_BOX_BOX, 16'sd32767, 16'sd32767, 15'h7fff, 15'h7fff, 0,
             -16'sd32768, -16'sd32768, 15'h7fff, 15'h7fff, 0);
    send_req(KIND_CIRC_CIRC, 16'sd0, 16'sd0, 0, 0, 15'd2, 16'sd6, 16'sd8, 0, 0, 15'd8);
    send_req(KIND_CIRC_CIRC, 16'sd0, 16'sd0, 0, 0, 15'd2, 16'sd6, 16'sd8, 0, 0, 15'd7);
    send_req(KIND_CIRC_CIRC, -16'sd32768, -16'sd32768, 0, 0, 15'h7fff, 16'sd32767, 16'sd32767,
             0, 0, 15'h7fff);
    send_req(KIND_BOX_CIRC, 16'sd0, 16'sd0, 15'd10, 15'd10, 0, 16'sd5, 16'sd5, 0, 0, 15'd1);
    send_req(KIND_BOX_CIRC, 16'sd0, 16'sd0, 15'd10, 15'd10, 0, 16'sd5, -16'sd3, 0, 0, 15'd3);
    send_req(KIND_BOX_CIRC, 16'sd0, 16'sd0, 15'd10, 15'd10, 0, 16'sd5, -16'sd4, 0, 0, 15'd3);
    send_req(KIND_BOX_CIRC, 16'sd0, 16'sd0, 15'd10, 15'd10, 0, -16'sd3, -16'sd4, 0, 0, 15'd5);
    // circle swallowing the whole box: no edge hit, center outside
    send_req(KIND_BOX_CIRC, 16'sd0, 16'sd0, 15'd2, 15'd2, 0, -16'sd1, -16'sd1, 0, 0, 15'd50);
    // zero-length edges
    send_req(KIND_BOX_CIRC, 16'sd0, 16'sd0, 15'd0, 15'd0, 0, 16'sd3, 16'sd4, 0, 0, 15'd5);
    send_req(KIND_BOX_CIRC, 16'sd0, 16'sd0, 15'd0, 15'd10, 0, 16'sd3, 16'sd5, 0, 0, 15'd3);
    send_req(KIND_BOX_CIRC, -16'sd32768, -16'sd32768, 15'h7fff, 15'h7fff, 15'h7fff,
             16'sd32767, 16'sd32767, 15'h7fff, 15'h7fff, 15'h7fff);
    send_req(3'd5, 16'sd0, 16'sd0, 0, 0, 0, 16'sd0, 16'sd0, 0, 0, 0);
    send_req(3'd6, 16'sd0, 16'sd0, 0, 0, 0, 16'sd0, 16'sd0, 0, 0, 0);
    send_req(3'd7, -16'sd1, -16'sd1, 15'h7fff, 15'h7fff, 15'h7fff, -16'sd1, -16'sd1,
             15'h7fff, 15'h7fff, 15'h7fff);
    drain();

    // Random phases with varying idle/stall mixes.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 48; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 48; end
        default: begin send_idle_pct = 38; recv_stall_pct = 38; end
      endcase
      for (int i = 0; i < N_RANDOM / 4; i++) begin
        if (ph == 2 && i == 50) begin
          // long receiver hold-off while requests keep coming: fills both queues
          fork
            begin
              hold_off = 1'b1;
              repeat (60) @(posedge clk);
              hold_off = 1'b0;
            end
          join_none
        end
        send_random();
      end
      drain();
    end

    drain();
    if (fail_count == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
